[sv/adam_pkg.sv]
// Package for the Adam parameter update pipeline.
// Holds request/result structs, register indexes and pipeline depths.
// No dependencies; used by adam_optimizer_update_unit and adam_chk.
package adam_pkg;

  localparam int FRAC        = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;

  localparam logic [CFG_IDX_W-1:0] REG_LR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C2  = 3'd6;

  localparam logic [24:0] ONE_Q24 = 25'h1000000;

  localparam logic [23:0] LR_RST  = 24'd16777;
  localparam logic [23:0] B1_RST  = 24'd15099494;
  localparam logic [23:0] B2_RST  = 24'd16760438;
  localparam logic [23:0] EPS_RST = 24'd1;
  localparam logic [23:0] WD_RST  = 24'd0;
  localparam logic [24:0] C_RST   = 25'h1000000;

  localparam int FRONT_STAGES = 6;
  localparam int HAT_STAGES   = 56;
  localparam int SQRT_STAGES  = 40;
  localparam int MUL_STAGES   = 3;
  localparam int STEP_STAGES  = 34;
  localparam int LAT = FRONT_STAGES + HAT_STAGES + SQRT_STAGES + MUL_STAGES + STEP_STAGES + 1;

  typedef struct packed {
    logic signed [31:0] param_value;
    logic signed [31:0] grad_value;
    logic signed [31:0] first_moment;
    logic        [31:0] second_moment;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_param;
    logic signed [31:0] new_first_moment;
    logic        [31:0] new_second_moment;
    logic               saturated;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] m_new;
    logic        [31:0] v_new;
    logic               flag;
    logic               last;
    logic               neg;
  } carry_t;

endpackage

[sv/adam_optimizer_update_unit.sv]
// Top level of the Adam parameter update pipeline.
// Depends on adam_pkg for structs, register indexes and stage counts.
//
// Streams one parameter update per clock. A request enters every cycle and
// passes adam_pkg::LAT (140) register stages. The stage count is set by the
// bit-serial stages: 56 for the two bias-correction dividers run side by side,
// 40 for the square root and 34 for the step divider, plus ten stages of
// multiply, round and saturate. The whole pipeline holds while a result waits
// at the output and out_ready is low; in_ready follows that hold.
// The user must write configuration only while the pipeline is empty; the
// block itself does not enforce it.
module adam_optimizer_update_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  adam_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output adam_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [adam_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [adam_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int HS = adam_pkg::HAT_STAGES;
  localparam int SS = adam_pkg::SQRT_STAGES;
  localparam int TS = adam_pkg::STEP_STAGES;
  localparam int LT = adam_pkg::LAT;

  logic [23:0] lr_r, b1_r, b2_r, eps_r, wd_r;
  logic [24:0] c1_r, c2_r;
  logic [24:0] c1_eff, c2_eff;
  logic [23:0] eps_eff;
  logic [24:0] f1, f2;
  logic        en;
  logic [LT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= adam_pkg::LR_RST;
      b1_r  <= adam_pkg::B1_RST;
      b2_r  <= adam_pkg::B2_RST;
      eps_r <= adam_pkg::EPS_RST;
      wd_r  <= adam_pkg::WD_RST;
      c1_r  <= adam_pkg::C_RST;
      c2_r  <= adam_pkg::C_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        adam_pkg::REG_LR:  lr_r  <= cfg_wdata[23:0];
        adam_pkg::REG_B1:  b1_r  <= cfg_wdata[23:0];
        adam_pkg::REG_B2:  b2_r  <= cfg_wdata[23:0];
        adam_pkg::REG_EPS: eps_r <= cfg_wdata[23:0];
        adam_pkg::REG_WD:  wd_r  <= cfg_wdata[23:0];
        adam_pkg::REG_C1:  c1_r  <= cfg_wdata;
        adam_pkg::REG_C2:  c2_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign c1_eff  = (c1_r == '0) ? 25'd1 : c1_r;
  assign c2_eff  = (c2_r == '0) ? 25'd1 : c2_r;
  assign eps_eff = (eps_r == '0) ? 24'd1 : eps_r;
  assign f1      = adam_pkg::ONE_Q24 - {1'b0, b1_r};
  assign f2      = adam_pkg::ONE_Q24 - {1'b0, b2_r};

  // advance everything unless a result is held at the output
  assign en       = !vld_r[LT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LT-2:0], in_valid};
    end
  end

  // front: weight decay, moments, rounding and saturation
  adam_pkg::in_t      s1_in_r, s2_in_r, s3_in_r;
  logic signed [56:0] s1_wdp_r;
  logic signed [57:0] s2_rnd;
  logic signed [33:0] s2_ge_r;
  logic signed [33:0] s2_ge_nxt;
  logic signed [56:0] s3_pm1_r;
  logic signed [59:0] s3_pm2_r;
  logic        [65:0] s3_gsq_r;
  logic        [32:0] s3_gmag;
  logic signed [60:0] s4_msum, s4_mrnd;
  logic        [65:0] s4_gsum;
  adam_pkg::carry_t   s4_c_r, s4_c_nxt, s5_c_r, s6_c_r, s6_c_nxt;
  logic        [41:0] s4_g2_r;
  logic        [42:0] s5_t1_r;
  logic        [55:0] s5_t2_r;
  logic        [48:0] s5_t3_r;
  logic        [31:0] s5_mabs_r, s6_mabs_r;
  logic        [56:0] s6_low;
  logic        [43:0] s6_vn;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_in_r  <= in_data;
      s1_wdp_r <= $signed({1'b0, wd_r}) * in_data.param_value;
    end
  end

  assign s2_rnd    = ($signed({s1_wdp_r[56], s1_wdp_r}) + 58'sd8388608) >>> adam_pkg::FRAC;
  assign s2_ge_nxt = $signed({{2{s1_in_r.grad_value[31]}}, s1_in_r.grad_value}) + s2_rnd[33:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_in_r <= s1_in_r;
      s2_ge_r <= s2_ge_nxt;
    end
  end

  assign s3_gmag = s2_ge_r[33] ? 33'(-s2_ge_r) : s2_ge_r[32:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_in_r  <= s2_in_r;
      s3_pm1_r <= $signed({1'b0, b1_r}) * s2_in_r.first_moment;
      s3_pm2_r <= $signed({1'b0, f1}) * s2_ge_r;
      s3_gsq_r <= s3_gmag * s3_gmag;
    end
  end

  always_comb begin
    s4_msum = $signed({{4{s3_pm1_r[56]}}, s3_pm1_r}) + $signed({s3_pm2_r[59], s3_pm2_r})
              + 61'sd8388608;
    s4_mrnd = s4_msum >>> adam_pkg::FRAC;
    s4_gsum = s3_gsq_r + 66'd8388608;
    s4_c_nxt.p    = s3_in_r.param_value;
    s4_c_nxt.v_new = s3_in_r.second_moment;
    s4_c_nxt.last = s3_in_r.last_element;
    s4_c_nxt.flag = 1'b0;
    if (s4_mrnd > 61'sd2147483647) begin
      s4_c_nxt.m_new = 32'sh7FFFFFFF;
      s4_c_nxt.flag  = 1'b1;
    end else if (s4_mrnd < -61'sd2147483648) begin
      s4_c_nxt.m_new = 32'sh80000000;
      s4_c_nxt.flag  = 1'b1;
    end else begin
      s4_c_nxt.m_new = s4_mrnd[31:0];
    end
    s4_c_nxt.neg = s4_c_nxt.m_new[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c_r  <= s4_c_nxt;
      s4_g2_r <= s4_gsum[65:24];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_c_r    <= s4_c_r;
      s5_t1_r   <= f2 * s4_g2_r[41:24];
      s5_t2_r   <= b2_r * s4_c_r.v_new;
      s5_t3_r   <= f2 * s4_g2_r[23:0];
      s5_mabs_r <= s4_c_r.neg ? 32'(-s4_c_r.m_new) : s4_c_r.m_new;
    end
  end

  always_comb begin
    s6_low   = 57'(s5_t2_r) + 57'(s5_t3_r) + 57'd8388608;
    s6_vn    = 44'(s5_t1_r) + 44'(s6_low[56:24]);
    s6_c_nxt = s5_c_r;
    if (s6_vn > 44'hFFFFFFFF) begin
      s6_c_nxt.v_new = 32'hFFFFFFFF;
      s6_c_nxt.flag  = 1'b1;
    end else begin
      s6_c_nxt.v_new = s6_vn[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_c_r    <= s6_c_nxt;
      s6_mabs_r <= s5_mabs_r;
    end
  end

  // bias correction: two restoring dividers, one quotient bit per stage
  logic [24:0]      hm_r_r [HS];
  logic [55:0]      hm_x_r [HS];
  logic [24:0]      hv_r_r [HS];
  logic [55:0]      hv_x_r [HS];
  adam_pkg::carry_t h_c_r  [HS];

  for (genvar k = 0; k < HS; k++) begin : g_hat
    logic [24:0]      rm_in, rv_in;
    logic [55:0]      xm_in, xv_in;
    adam_pkg::carry_t c_in;
    logic [25:0]      rm_sh, rv_sh;
    logic             qm, qv;
    if (k == 0) begin : g_first
      assign rm_in = '0;
      assign rv_in = '0;
      assign xm_in = {s6_mabs_r, 24'd0};
      assign xv_in = {s6_c_r.v_new, 24'd0};
      assign c_in  = s6_c_r;
    end else begin : g_next
      assign rm_in = hm_r_r[k-1];
      assign rv_in = hv_r_r[k-1];
      assign xm_in = hm_x_r[k-1];
      assign xv_in = hv_x_r[k-1];
      assign c_in  = h_c_r[k-1];
    end
    assign rm_sh = {rm_in, xm_in[55]};
    assign rv_sh = {rv_in, xv_in[55]};
    assign qm    = rm_sh >= {1'b0, c1_eff};
    assign qv    = rv_sh >= {1'b0, c2_eff};
    always_ff @(posedge clk) begin
      if (en) begin
        hm_r_r[k] <= qm ? 25'(rm_sh - {1'b0, c1_eff}) : rm_sh[24:0];
        hv_r_r[k] <= qv ? 25'(rv_sh - {1'b0, c2_eff}) : rv_sh[24:0];
        hm_x_r[k] <= {xm_in[54:0], qm};
        hv_x_r[k] <= {xv_in[54:0], qv};
        h_c_r[k]  <= c_in;
      end
    end
  end

  // square root of v_hat scaled by 2^24, one result bit per stage
  logic [55:0]      sq_x_r  [SS];
  logic [41:0]      sq_r_r  [SS];
  logic [39:0]      sq_q_r  [SS];
  logic [55:0]      sq_mh_r [SS];
  adam_pkg::carry_t sq_c_r  [SS];

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [55:0]      x_in, mh_in;
    logic [41:0]      r_in;
    logic [39:0]      q_in;
    adam_pkg::carry_t c_in;
    logic [43:0]      rs, t;
    logic             take;
    if (k == 0) begin : g_first
      assign x_in  = hv_x_r[HS-1];
      assign r_in  = '0;
      assign q_in  = '0;
      assign mh_in = hm_x_r[HS-1];
      assign c_in  = h_c_r[HS-1];
    end else begin : g_next
      assign x_in  = sq_x_r[k-1];
      assign r_in  = sq_r_r[k-1];
      assign q_in  = sq_q_r[k-1];
      assign mh_in = sq_mh_r[k-1];
      assign c_in  = sq_c_r[k-1];
    end
    assign rs   = {r_in, x_in[55:54]};
    assign t    = {2'b00, q_in, 2'b01};
    assign take = rs >= t;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[k]  <= {x_in[53:0], 2'b00};
        sq_r_r[k]  <= take ? 42'(rs - t) : rs[41:0];
        sq_q_r[k]  <= {q_in[38:0], take};
        sq_mh_r[k] <= mh_in;
        sq_c_r[k]  <= c_in;
      end
    end
  end

  // lr * m_hat in two partial products, then the step divider setup
  logic [47:0]      ma_pa_r;
  logic [55:0]      ma_pb_r;
  logic [40:0]      ma_den_r, mb_den_r, mc_den_r;
  logic [79:0]      mb_prod_r;
  adam_pkg::carry_t ma_c_r, mb_c_r, mc_c_r;
  logic [40:0]      mc_r_r;
  logic [33:0]      mc_x_r;
  logic             mc_ovf_r;
  logic [45:0]      mc_top;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_pa_r  <= lr_r * sq_mh_r[SS-1][55:32];
      ma_pb_r  <= lr_r * sq_mh_r[SS-1][31:0];
      ma_den_r <= 41'(sq_q_r[SS-1]) + 41'(eps_eff);
      ma_c_r   <= sq_c_r[SS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb_prod_r <= {ma_pa_r, 32'd0} + {24'd0, ma_pb_r};
      mb_den_r  <= ma_den_r;
      mb_c_r    <= ma_c_r;
    end
  end

  assign mc_top = mb_prod_r[79:34];

  // a quotient of 2^34 or more saturates the parameter anyway
  always_ff @(posedge clk) begin
    if (en) begin
      mc_ovf_r <= mc_top >= 46'(mb_den_r);
      mc_r_r   <= mc_top[40:0];
      mc_x_r   <= mb_prod_r[33:0];
      mc_den_r <= mb_den_r;
      mc_c_r   <= mb_c_r;
    end
  end

  logic [40:0]      st_r_r   [TS];
  logic [33:0]      st_x_r   [TS];
  logic [40:0]      st_den_r [TS];
  logic             st_ovf_r [TS];
  adam_pkg::carry_t st_c_r   [TS];

  for (genvar k = 0; k < TS; k++) begin : g_step
    logic [40:0]      r_in, den_in;
    logic [33:0]      x_in;
    logic             ovf_in;
    adam_pkg::carry_t c_in;
    logic [41:0]      rs;
    logic             qb;
    if (k == 0) begin : g_first
      assign r_in   = mc_r_r;
      assign x_in   = mc_x_r;
      assign den_in = mc_den_r;
      assign ovf_in = mc_ovf_r;
      assign c_in   = mc_c_r;
    end else begin : g_next
      assign r_in   = st_r_r[k-1];
      assign x_in   = st_x_r[k-1];
      assign den_in = st_den_r[k-1];
      assign ovf_in = st_ovf_r[k-1];
      assign c_in   = st_c_r[k-1];
    end
    assign rs = {r_in, x_in[33]};
    assign qb = rs >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        st_r_r[k]   <= qb ? 41'(rs - {1'b0, den_in}) : rs[40:0];
        st_x_r[k]   <= {x_in[32:0], qb};
        st_den_r[k] <= den_in;
        st_ovf_r[k] <= ovf_in;
        st_c_r[k]   <= c_in;
      end
    end
  end

  // apply step and saturate
  adam_pkg::carry_t   oc;
  logic        [34:0] o_step;
  logic signed [35:0] o_np;
  adam_pkg::out_t     out_nxt, out_data_r;

  always_comb begin
    oc     = st_c_r[TS-1];
    o_step = st_ovf_r[TS-1] ? 35'h400000000 : {1'b0, st_x_r[TS-1]};
    if (oc.neg) begin
      o_np = $signed({{4{oc.p[31]}}, oc.p}) + $signed({1'b0, o_step});
    end else begin
      o_np = $signed({{4{oc.p[31]}}, oc.p}) - $signed({1'b0, o_step});
    end
    out_nxt.new_first_moment  = oc.m_new;
    out_nxt.new_second_moment = oc.v_new;
    out_nxt.last_out          = oc.last;
    out_nxt.saturated         = oc.flag;
    if (o_np > 36'sd2147483647) begin
      out_nxt.new_param = 32'sh7FFFFFFF;
      out_nxt.saturated = 1'b1;
    end else if (o_np < -36'sd2147483648) begin
      out_nxt.new_param = 32'sh80000000;
      out_nxt.saturated = 1'b1;
    end else begin
      out_nxt.new_param = o_np[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LT-1];
  assign out_data  = out_data_r;

endmodule

[sv/adam_chk.sv]
// Port-level checker for adam_optimizer_update_unit.
// Depends on adam_pkg; bound to the top level at the end of this file.
module adam_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input adam_pkg::in_t                     in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input adam_pkg::out_t                    out_data,
  input logic                              cfg_we
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output hold");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_request_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed or dropped");

  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !out_valid)
    else $error("register written while a result is pending");

endmodule

bind adam_optimizer_update_unit adam_chk u_adam_chk (.*);

[sim/tb_adam_optimizer_update_unit.sv]
// Self-checking testbench for adam_optimizer_update_unit.
// Drives parameter update requests through several register settings and checks
// every result against an in-bench model. Depends on adam_pkg and the RTL.
module tb_adam_optimizer_update_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import adam_pkg::*;

  localparam longint HALF = 64'd8388608;
  localparam longint UNIT = 64'd16777216;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adam_optimizer_update_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  longint lr_q, b1_q, b2_q, eps_q, wd_q, c1_q, c2_q;
  in_t pending_requests[$];
  out_t expected_updates[$];
  int errors = 0;
  int cycles = 0;
  int n_checked = 0;
  int n_sat = 0;
  logic accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint round_q24(longint x);
    if (x >= 0) begin
      return (x + HALF) >>> 24;
    end
    return -((-x + HALF - 1) >>> 24);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic out_t adam_update_predict(in_t req);
    out_t res;
    longint p, g, m, ge, mn, np, mag;
    logic [127:0] gm, g2, vn, mh, vh, den, st, c1, c2, eps;
    bit neg, flag;
    flag = 0;
    p = longint'(req.param_value);
    g = longint'(req.grad_value);
    m = longint'(req.first_moment);
    ge = g + round_q24(wd_q * p);
    mn = round_q24(b1_q * m + (UNIT - b1_q) * ge);
    if (mn > 64'sd2147483647) begin
      mn = 64'sd2147483647; flag = 1;
    end else if (mn < -64'sd2147483648) begin
      mn = -64'sd2147483648; flag = 1;
    end
    gm = (ge < 0) ? 128'(-ge) : 128'(ge);
    g2 = (gm * gm + 128'(HALF)) >> 24;
    vn = (128'(b2_q) * 128'(req.second_moment) + 128'(UNIT - b2_q) * g2 + 128'(HALF)) >> 24;
    if (vn > 128'hFFFFFFFF) begin
      vn = 128'hFFFFFFFF; flag = 1;
    end
    c1 = (c1_q == 0) ? 128'd1 : 128'(c1_q);
    c2 = (c2_q == 0) ? 128'd1 : 128'(c2_q);
    eps = (eps_q == 0) ? 128'd1 : 128'(eps_q);
    neg = mn < 0;
    mag = neg ? -mn : mn;
    mh = (128'(mag) << 24) / c1;
    vh = (vn << 24) / c2;
    den = isqrt(vh << 24) + eps;
    st = (128'(lr_q) * mh) / den;
    if (st > (128'd1 << 40)) st = 128'd1 << 40;
    np = neg ? p + longint'(st) : p - longint'(st);
    if (np > 64'sd2147483647) begin
      np = 64'sd2147483647; flag = 1;
    end else if (np < -64'sd2147483648) begin
      np = -64'sd2147483648; flag = 1;
    end
    res.new_param = np[31:0];
    res.new_first_moment = mn[31:0];
    res.new_second_moment = vn[31:0];
    res.saturated = flag;
    res.last_out = req.last_element;
    return res;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LR:  lr_q = val[23:0];
      REG_B1:  b1_q = val[23:0];
      REG_B2:  b2_q = val[23:0];
      REG_EPS: eps_q = val[23:0];
      REG_WD:  wd_q = val[23:0];
      REG_C1:  c1_q = val;
      REG_C2:  c2_q = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] lr, logic [CFG_DATA_W-1:0] b1,
                           logic [CFG_DATA_W-1:0] b2, logic [CFG_DATA_W-1:0] eps,
                           logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] c1,
                           logic [CFG_DATA_W-1:0] c2);
    write_reg(REG_LR, lr);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_EPS, eps);
    write_reg(REG_WD, wd);
    write_reg(REG_C1, c1);
    write_reg(REG_C2, c2);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      2: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  task automatic queue_random(int count);
    in_t r;
    for (int i = 0; i < count; i++) begin
      r.param_value = rand_word();
      r.grad_value = rand_word();
      r.first_moment = rand_word();
      r.second_moment = ($urandom_range(0, 2) == 0) ? $urandom() : (rand_word() & 32'h0FFFFFFF);
      r.last_element = ($urandom_range(0, 7) == 0);
      pending_requests.push_back(r);
    end
  endtask

  task automatic queue_req(logic [31:0] p, logic [31:0] g, logic [31:0] m,
                           logic [31:0] v, logic last);
    in_t r;
    r.param_value = p;
    r.grad_value = g;
    r.first_moment = m;
    r.second_moment = v;
    r.last_element = last;
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid);
    wait (expected_updates.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    logic nv;
    in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!in_valid || accepted) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        nd = pending_requests.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (cycles % 7) < 3;
    endcase
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    out_t exp_r;
    cycles <= cycles + 1;
    accepted <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_updates.push_back(adam_update_predict(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, out_data);
      end else begin
        exp_r = expected_updates.pop_front();
        n_checked++;
        if (exp_r.saturated) n_sat++;
        if (out_data !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected p=%h m=%h v=%h sat=%b last=%b", $realtime,
                   exp_r.new_param, exp_r.new_first_moment, exp_r.new_second_moment,
                   exp_r.saturated, exp_r.last_out);
          $display("%0t:          actual p=%h m=%h v=%h sat=%b last=%b", $realtime,
                   out_data.new_param, out_data.new_first_moment,
                   out_data.new_second_moment, out_data.saturated, out_data.last_out);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    lr_q = LR_RST; b1_q = B1_RST; b2_q = B2_RST; eps_q = EPS_RST;
    wd_q = WD_RST; c1_q = C_RST; c2_q = C_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, directed corners
    queue_req(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
    queue_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 1'b0);
    queue_req(32'h01000000, 32'hFF000000, 32'h00000000, 32'h01000000, 1'b1);
    queue_req(32'hFF000000, 32'h01000000, 32'hFFF00000, 32'h00000001, 1'b0);
    queue_req(32'h80000000, 32'h00001000, 32'h7FFFFFFF, 32'h0, 1'b0);
    queue_req(32'h7FFFFFFF, 32'hFFFFF000, 32'h80000000, 32'h0, 1'b1);
    drain();

    // registers at their maxima but corrections at one, unknown index too
    write_reg(3'd7, '1);
    write_all(25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF,
              25'h1000000, 25'h1000000);
    queue_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
    queue_req(32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 1'b0);
    queue_random(40);
    drain();

    // zero decays, zero offset, zero corrections, huge step
    write_all(25'hFFFFFF, 25'h0, 25'h0, 25'h0, 25'hFFFFFF, 25'h0, 25'h0);
    queue_req(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_req(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1);
    queue_req(32'h00000000, 32'h00000001, 32'h0, 32'h0, 1'b0);
    queue_req(32'h00000000, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0);
    queue_random(60);
    drain();

    // oversized corrections, all-ones data writes
    write_all('1, 25'h800000, 25'h800000, 25'h1, 25'h0, '1, 25'h1FFFFFF);
    queue_random(60);
    drain();

    // random settings, mostly well-behaved training-like values
    for (int ph = 0; ph < 8; ph++) begin
      write_all(25'($urandom_range(0, 25'hFFFFFF)), 25'($urandom_range(25'hC00000, 25'hFFFFFF)),
                25'($urandom_range(25'hF00000, 25'hFFFFFF)), 25'($urandom_range(1, 25'h1000)),
                25'($urandom_range(0, 25'h10000)), 25'($urandom_range(1, 25'h1000000)),
                25'($urandom_range(1, 25'h1000000)));
      queue_random(80);
      drain();
    end
    write_all(25'(LR_RST), 25'(B1_RST), 25'(B2_RST), 25'(EPS_RST), 25'(WD_RST),
              C_RST, C_RST);
    queue_random(50);
    drain();

    repeat (LAT + 20) @(posedge clk);
    if (expected_updates.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $realtime, expected_updates.size());
    end
    $display("Covered %0d updates over 13 register settings, %0d of them saturating.",
             n_checked, n_sat);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
